>>> hdl/hcd_pkg.sv
// ----------------------------------------------------------------------------
// hcd_pkg
// Shared types, phase codes, character codes and helpers for the chunked
// transfer deframer.
// ----------------------------------------------------------------------------
package hcd_pkg;

	// Default width of the chunk size accumulator and the payload counter
	localparam int HCD_SIZE_BITS = 32;

	// Parser phases
	localparam logic [2:0] PH_LEAD  = 3'd0;
	localparam logic [2:0] PH_NUM   = 3'd1;
	localparam logic [2:0] PH_SKIP  = 3'd2;
	localparam logic [2:0] PH_DATA  = 3'd3;
	localparam logic [2:0] PH_CRLF  = 3'd4;
	localparam logic [2:0] PH_TRAIL = 3'd5;
	localparam logic [2:0] PH_DONE  = 3'd6;

	// Number prefix progress
	localparam logic [1:0] PFX_NONE   = 2'd0;
	localparam logic [1:0] PFX_ZERO   = 2'd1;
	localparam logic [1:0] PFX_HEX    = 2'd2;
	localparam logic [1:0] PFX_DIGITS = 2'd3;

	// Character codes
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	// Line trailer char count saturation limit
	localparam logic [1:0] LINE_CHARS_MAX = 2'd3;

	// Narrow parser state carried between bytes
	typedef struct packed {
		logic [2:0] phase;
		logic       size_negative;
		logic [1:0] prefix_progress;
		logic       crlf_count;
		logic [1:0] line_chars;
		logic       line_first_cr;
	} hcd_ctrl_t;

	// One result transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       kind;
		logic       chunk_end;
	} hcd_res_t;

	// Decode a hex digit: bit 4 is the valid flag, bits 3:0 the value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

>>> hdl/http_chunked_deframer_core.sv
// ----------------------------------------------------------------------------
// http_chunked_deframer_core
// HTTP/1.1 chunked transfer deframer: one body byte per transaction in,
// payload bytes and an end marker out.
// ----------------------------------------------------------------------------
// Result path: an accepted byte passes the input register, then the result
// register or its skid entry. Throughput: one byte per cycle while the output
// does not stall; the parse state updates in a single step.
// Reset: parser returns to the start of a size line, chunked mode enabled,
// all pipeline and output entries empty.
module http_chunked_deframer_core #(
	parameter int SIZE_BITS = hcd_pkg::HCD_SIZE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       kind,
	output logic       chunk_end
);

	logic                 enable_q;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 adv;
	logic                 buf_ready;
	hcd_pkg::hcd_ctrl_t   ctrl_q;
	hcd_pkg::hcd_ctrl_t   ctrl_nxt;
	logic [SIZE_BITS-1:0] accum_q;
	logic [SIZE_BITS-1:0] accum_nxt;
	logic [SIZE_BITS-1:0] remain_q;
	logic [SIZE_BITS-1:0] remain_nxt;
	logic                 res_valid;
	hcd_pkg::hcd_res_t    res;
	hcd_pkg::hcd_res_t    out_res;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && buf_ready;
	assign in_ready  = !valid_s1 || adv;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid) begin
			enable_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Parse state, advanced once per processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= '{phase: hcd_pkg::PH_LEAD, prefix_progress: hcd_pkg::PFX_NONE,
			              default: '0};
			accum_q  <= '0;
			remain_q <= '0;
		end else if (adv) begin
			ctrl_q   <= ctrl_nxt;
			accum_q  <= accum_nxt;
			remain_q <= remain_nxt;
		end
	end

	hcd_step #(
		.SIZE_BITS(SIZE_BITS)
	) u_step (
		.enable    (enable_q),
		.c         (byte_s1),
		.ctrl_cur  (ctrl_q),
		.accum_cur (accum_q),
		.remain_cur(remain_q),
		.ctrl_nxt  (ctrl_nxt),
		.accum_nxt (accum_nxt),
		.remain_nxt(remain_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	hcd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv && res_valid),
		.push_res  (res),
		.push_ready(buf_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign data_byte = out_res.data_byte;
	assign kind      = out_res.kind;
	assign chunk_end = out_res.chunk_end;

endmodule

>>> hdl/hcd_step.sv
// ----------------------------------------------------------------------------
// hcd_step
// Per-byte next-state and result logic of the chunked deframer.
// ----------------------------------------------------------------------------
module hcd_step #(
	parameter int SIZE_BITS = hcd_pkg::HCD_SIZE_BITS
) (
	input  logic                 enable,
	input  logic [7:0]           c,
	input  hcd_pkg::hcd_ctrl_t   ctrl_cur,
	input  logic [SIZE_BITS-1:0] accum_cur,
	input  logic [SIZE_BITS-1:0] remain_cur,
	output hcd_pkg::hcd_ctrl_t   ctrl_nxt,
	output logic [SIZE_BITS-1:0] accum_nxt,
	output logic [SIZE_BITS-1:0] remain_nxt,
	output logic                 res_valid,
	output hcd_pkg::hcd_res_t    res
);

	logic                 is_lf;
	logic                 is_blank;
	logic                 is_x;
	logic [4:0]           hex;
	logic                 size_term;
	logic                 accum_ovf;
	logic [SIZE_BITS-1:0] accum_shift;
	logic [SIZE_BITS-1:0] remain_dec;

	// Character classes and shared arithmetic
	assign is_lf     = (c == hcd_pkg::CH_LF);
	assign is_blank  = (c == hcd_pkg::CH_SPACE) || (c == hcd_pkg::CH_TAB) ||
	                   (c == hcd_pkg::CH_CR) || (c == hcd_pkg::CH_VT) ||
	                   (c == hcd_pkg::CH_FF);
	assign is_x      = (c == hcd_pkg::CH_LOW_X) || (c == hcd_pkg::CH_UP_X);
	assign hex       = hcd_pkg::hex_decode(c);
	assign size_term = ctrl_cur.size_negative || (accum_cur == '0);
	// accum * 16 + d overflows exactly when the top nibble is non-zero
	assign accum_ovf   = (accum_cur[SIZE_BITS-1 -: 4] != 4'd0);
	assign accum_shift = accum_ovf ? {SIZE_BITS{1'b1}} :
	                     {accum_cur[SIZE_BITS-5:0], hex[3:0]};
	assign remain_dec  = (remain_cur == '0) ? remain_cur : remain_cur - SIZE_BITS'(1);

	always_comb begin
		ctrl_nxt   = ctrl_cur;
		accum_nxt  = accum_cur;
		remain_nxt = remain_cur;
		res_valid  = 1'b0;
		res        = '0;

		priority if (ctrl_cur.phase == hcd_pkg::PH_DONE) begin
			// drop everything after the end marker
		end else if (!enable) begin
			// raw mode: pass the byte, leave the parse as it stands
			res_valid     = 1'b1;
			res.data_byte = c;
			res.kind      = hcd_pkg::KIND_PAYLOAD;
		end else begin
			unique case (ctrl_cur.phase)
				hcd_pkg::PH_LEAD, hcd_pkg::PH_NUM, hcd_pkg::PH_SKIP: begin
					priority if (is_lf) begin
						// end of size line
						if (size_term) begin
							ctrl_nxt.phase         = hcd_pkg::PH_TRAIL;
							ctrl_nxt.line_chars    = 2'd0;
							ctrl_nxt.line_first_cr = 1'b0;
						end else begin
							remain_nxt     = accum_cur;
							ctrl_nxt.phase = hcd_pkg::PH_DATA;
						end
					end else if (ctrl_cur.phase == hcd_pkg::PH_SKIP) begin
						// ignore extension and junk up to LF
					end else if (ctrl_cur.phase == hcd_pkg::PH_LEAD && is_blank) begin
						// skip leading blanks
					end else if (ctrl_cur.phase == hcd_pkg::PH_LEAD &&
					             (c == hcd_pkg::CH_PLUS || c == hcd_pkg::CH_MINUS)) begin
						ctrl_nxt.size_negative = (c == hcd_pkg::CH_MINUS);
						ctrl_nxt.phase         = hcd_pkg::PH_NUM;
					end else if (ctrl_cur.prefix_progress == hcd_pkg::PFX_ZERO && is_x) begin
						ctrl_nxt.prefix_progress = hcd_pkg::PFX_HEX;
						ctrl_nxt.phase           = hcd_pkg::PH_NUM;
					end else if (!hex[4]) begin
						ctrl_nxt.phase = hcd_pkg::PH_SKIP;
					end else begin
						// accumulate one hex digit, saturating
						ctrl_nxt.prefix_progress =
							(ctrl_cur.prefix_progress == hcd_pkg::PFX_NONE && hex[3:0] == 4'd0) ?
							hcd_pkg::PFX_ZERO : hcd_pkg::PFX_DIGITS;
						accum_nxt      = accum_shift;
						ctrl_nxt.phase = hcd_pkg::PH_NUM;
					end
				end
				hcd_pkg::PH_DATA: begin
					// pass payload, mark the last byte of the chunk
					res_valid     = 1'b1;
					res.data_byte = c;
					res.kind      = hcd_pkg::KIND_PAYLOAD;
					remain_nxt    = remain_dec;
					if (remain_dec == '0) begin
						res.chunk_end      = 1'b1;
						ctrl_nxt.phase     = hcd_pkg::PH_CRLF;
						ctrl_nxt.crlf_count = 1'b0;
					end
				end
				hcd_pkg::PH_CRLF: begin
					// drop two bytes, then start the next size line
					if (!ctrl_cur.crlf_count) begin
						ctrl_nxt.crlf_count = 1'b1;
					end else begin
						ctrl_nxt.crlf_count      = 1'b0;
						ctrl_nxt.phase           = hcd_pkg::PH_LEAD;
						ctrl_nxt.size_negative   = 1'b0;
						ctrl_nxt.prefix_progress = hcd_pkg::PFX_NONE;
						accum_nxt                = '0;
					end
				end
				hcd_pkg::PH_TRAIL: begin
					if (is_lf) begin
						if (ctrl_cur.line_chars == 2'd0 ||
						    (ctrl_cur.line_chars == 2'd1 && ctrl_cur.line_first_cr)) begin
							// empty line: emit the end marker
							ctrl_nxt.phase = hcd_pkg::PH_DONE;
							res_valid      = 1'b1;
							res.kind       = hcd_pkg::KIND_END;
						end else begin
							ctrl_nxt.line_chars    = 2'd0;
							ctrl_nxt.line_first_cr = 1'b0;
						end
					end else begin
						if (ctrl_cur.line_chars == 2'd0) begin
							ctrl_nxt.line_first_cr = (c == hcd_pkg::CH_CR);
						end
						if (ctrl_cur.line_chars < hcd_pkg::LINE_CHARS_MAX) begin
							ctrl_nxt.line_chars = ctrl_cur.line_chars + 2'd1;
						end
					end
				end
				default: begin
					// unused phase code: drop the byte
				end
			endcase
		end
	end

endmodule

>>> hdl/hcd_out_buf.sv
// ----------------------------------------------------------------------------
// hcd_out_buf
// Result register with a skid entry, so that upstream ready is registered.
// ----------------------------------------------------------------------------
module hcd_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hcd_pkg::hcd_res_t push_res,
	output logic              push_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output hcd_pkg::hcd_res_t out_res
);

	logic              main_valid_q;
	logic              skid_valid_q;
	hcd_pkg::hcd_res_t main_q;
	hcd_pkg::hcd_res_t skid_q;

	assign push_ready = !skid_valid_q;
	assign out_valid  = main_valid_q;
	assign out_res    = main_q;

	// Control: refill the main entry from skid first, else park in skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q || out_ready) begin
				if (skid_valid_q) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					main_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (!main_valid_q || out_ready) begin
			main_q <= skid_valid_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunked transfer deframer. Body bytes go in
// over a valid/ready channel with random gaps and a random output stall.
// A scoreboard class tracks the parse and the enable bit, forecasts every
// payload byte and the end marker, and compares them field by field as they
// leave. The stream is made of well-formed chunks with random content,
// broken separators and extensions, raw mode bursts that cut into any point
// of the parse, and one terminating size line per run.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int SB             = hcd_pkg::HCD_SIZE_BITS;
	localparam int TOTAL_ITEMS    = 750;
	localparam int SETTLE_CYCLES  = 6;
	localparam int END_CYCLES     = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	// Characters that the package does not name
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_F   = 8'h66;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [7:0] CH_SEMI    = 8'h3B;

	// Ways to close the body at the end of the run
	typedef enum int {
		TAIL_ZERO,
		TAIL_NEG_EXT,
		TAIL_BLANKS,
		TAIL_BARE_PREFIX,
		TAIL_SIGN_BLANK,
		TAIL_EMPTY,
		TAIL_NEG_HUGE,
		TAIL_ZEROS_EXT,
		TAIL_HUGE
	} tail_kind_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_data  = 1'b0;
	logic       cfg_ready;
	logic       in_valid  = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       in_ready;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_byte;
	logic       kind;
	logic       chunk_end;

	logic        calm = 1'b0;
	int unsigned sent = 0;
	int unsigned quiet_cycles = 0;
	logic [7:0]  stream_q[$];

	// ------------------------------------------------------------------
	// Forecast of the deframer output and check of what it delivers
	// ------------------------------------------------------------------
	class deframer_scoreboard;
		hcd_pkg::hcd_res_t due_results[$];
		int unsigned       failures;
		logic              chunked_mode;
		logic [2:0]        phase;
		logic [SB-1:0]     size_accum;
		logic [SB-1:0]     bytes_left;
		logic              size_negative;
		logic [1:0]        prefix_state;
		logic              crlf_half;
		logic [1:0]        trailer_len;
		logic              trailer_cr_first;

		function new();
			failures         = 0;
			chunked_mode     = 1'b1;
			bytes_left       = '0;
			crlf_half        = 1'b0;
			trailer_len      = 2'd0;
			trailer_cr_first = 1'b0;
			open_size_line();
		endfunction

		function void open_size_line();
			phase         = hcd_pkg::PH_LEAD;
			size_accum    = '0;
			size_negative = 1'b0;
			prefix_state  = hcd_pkg::PFX_NONE;
		endfunction

		// Zero or negative sizes go to the trailer, others start a chunk
		function void close_size_line();
			if (size_negative || size_accum == '0) begin
				phase            = hcd_pkg::PH_TRAIL;
				trailer_len      = 2'd0;
				trailer_cr_first = 1'b0;
			end else begin
				bytes_left = size_accum;
				phase      = hcd_pkg::PH_DATA;
			end
		endfunction

		// Prefix and hex digits, saturating the accumulator
		function void number_char(logic [7:0] c);
			int            digit;
			logic [SB+3:0] grown;
			if (c == hcd_pkg::CH_LF) begin
				close_size_line();
				return;
			end
			if (prefix_state == hcd_pkg::PFX_ZERO &&
			    (c == hcd_pkg::CH_LOW_X || c == hcd_pkg::CH_UP_X)) begin
				prefix_state = hcd_pkg::PFX_HEX;
				phase        = hcd_pkg::PH_NUM;
				return;
			end
			if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) digit = int'(c) - int'(CH_DIGIT_0);
			else if (c >= CH_LOW_A && c <= CH_LOW_F) digit = int'(c) - int'(CH_LOW_A) + 10;
			else if (c >= CH_UP_A && c <= CH_UP_F) digit = int'(c) - int'(CH_UP_A) + 10;
			else digit = -1;
			if (digit < 0) begin
				phase = hcd_pkg::PH_SKIP;
				return;
			end
			prefix_state = (prefix_state == hcd_pkg::PFX_NONE && digit == 0) ?
			               hcd_pkg::PFX_ZERO : hcd_pkg::PFX_DIGITS;
			grown        = ({4'b0, size_accum} << 4) | (SB+4)'(digit[3:0]);
			size_accum   = (grown[SB+3:SB] != 4'd0) ? '1 : grown[SB-1:0];
			phase        = hcd_pkg::PH_NUM;
		endfunction

		function void set_mode(logic v);
			chunked_mode = v;
		endfunction

		// Advance the parse by one accepted byte and queue what it yields
		function void take_byte(logic [7:0] c);
			hcd_pkg::hcd_res_t r;
			r.data_byte = c;
			r.kind      = hcd_pkg::KIND_PAYLOAD;
			r.chunk_end = 1'b0;
			if (phase == hcd_pkg::PH_DONE) return;
			if (!chunked_mode) begin
				due_results = {due_results, r};
				return;
			end
			case (phase)
				hcd_pkg::PH_LEAD: begin
					if (c == hcd_pkg::CH_LF) begin
						close_size_line();
					end else if (c == hcd_pkg::CH_SPACE || c == hcd_pkg::CH_TAB ||
							c == hcd_pkg::CH_CR || c == hcd_pkg::CH_VT ||
							c == hcd_pkg::CH_FF) begin
						// skip leading blanks
					end else if (c == hcd_pkg::CH_PLUS || c == hcd_pkg::CH_MINUS) begin
						size_negative = (c == hcd_pkg::CH_MINUS);
						phase         = hcd_pkg::PH_NUM;
					end else begin
						number_char(c);
					end
				end
				hcd_pkg::PH_NUM: number_char(c);
				hcd_pkg::PH_SKIP: begin
					if (c == hcd_pkg::CH_LF) close_size_line();
				end
				hcd_pkg::PH_DATA: begin
					if (bytes_left != '0) bytes_left--;
					if (bytes_left == '0) begin
						r.chunk_end = 1'b1;
						phase       = hcd_pkg::PH_CRLF;
						crlf_half   = 1'b0;
					end
					due_results = {due_results, r};
				end
				hcd_pkg::PH_CRLF: begin
					if (!crlf_half) begin
						crlf_half = 1'b1;
					end else begin
						crlf_half = 1'b0;
						open_size_line();
					end
				end
				hcd_pkg::PH_TRAIL: begin
					if (c == hcd_pkg::CH_LF) begin
						if (trailer_len == 2'd0 ||
						    (trailer_len == 2'd1 && trailer_cr_first)) begin
							phase       = hcd_pkg::PH_DONE;
							r.data_byte = 8'h00;
							r.kind      = hcd_pkg::KIND_END;
							due_results = {due_results, r};
						end else begin
							trailer_len      = 2'd0;
							trailer_cr_first = 1'b0;
						end
					end else begin
						if (trailer_len == 2'd0) trailer_cr_first = (c == hcd_pkg::CH_CR);
						if (trailer_len < hcd_pkg::LINE_CHARS_MAX) trailer_len++;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [7:0] d, logic k, logic ce);
			hcd_pkg::hcd_res_t w;
			if (due_results.size() == 0) begin
				$error("unexpected result: data_byte %02h kind %0b chunk_end %0b", d, k, ce);
				failures++;
				return;
			end
			w = due_results.pop_front();
			if (d !== w.data_byte) begin
				$error("data_byte: expected %02h, got %02h", w.data_byte, d);
				failures++;
			end
			if (k !== w.kind) begin
				$error("kind: expected %0b, got %0b", w.kind, k);
				failures++;
			end
			if (ce !== w.chunk_end) begin
				$error("chunk_end: expected %0b, got %0b", w.chunk_end, ce);
				failures++;
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	deframer_scoreboard sb = new();

	http_chunked_deframer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_byte (data_byte),
		.kind      (kind),
		.chunk_end (chunk_end)
	);

	always #10 clk = ~clk;

	// Stall the result side at random, except in the calm stretch
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 30);
	end

	// Check every delivered result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(data_byte, kind, chunk_end);
	end

	// Abort when no channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("** http_chunked_deframer_core: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void add_byte(input logic [7:0] b);
		stream_q = {stream_q, b};
	endfunction

	function automatic logic [7:0] rand_text_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == hcd_pkg::CH_LF);
		return c;
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	function automatic void push_crlf();
		add_byte(hcd_pkg::CH_CR);
		add_byte(hcd_pkg::CH_LF);
	endfunction

	// Queue one chunk: size line in one of its many spellings, payload, separator
	function automatic void add_chunk();
		int unsigned size;
		int unsigned pick;
		logic [3:0]  nib;
		logic [7:0]  c;
		bit          started;
		pick = $urandom_range(0, 99);
		if (pick < 70) size = $urandom_range(1, 8);
		else if (pick < 97) size = $urandom_range(9, 40);
		else size = $urandom_range(41, 300);
		repeat ($urandom_range(0, 2)) begin
			case ($urandom_range(0, 4))
				0: add_byte(hcd_pkg::CH_SPACE);
				1: add_byte(hcd_pkg::CH_TAB);
				2: add_byte(hcd_pkg::CH_CR);
				3: add_byte(hcd_pkg::CH_VT);
				default: add_byte(hcd_pkg::CH_FF);
			endcase
		end
		if ($urandom_range(0, 3) == 0) add_byte(hcd_pkg::CH_PLUS);
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			add_byte(CH_DIGIT_0);
			add_byte(pick == 0 ? hcd_pkg::CH_LOW_X : hcd_pkg::CH_UP_X);
		end else if (pick < 4) begin
			repeat ($urandom_range(1, 3)) add_byte(CH_DIGIT_0);
		end
		// hex digits, random case, no leading zero
		started = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			nib = size[4*i +: 4];
			if (nib != 4'd0 || started || i == 0) begin
				started = 1'b1;
				if (nib < 4'd10) c = CH_DIGIT_0 + {4'd0, nib};
				else c = ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + {4'd0, nib} - 8'd10;
				add_byte(c);
			end
		end
		// line ending: plain, bare LF, extension, or junk after the digits
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			push_crlf();
		end else if (pick == 6) begin
			add_byte(hcd_pkg::CH_LF);
		end else if (pick < 9) begin
			add_byte(CH_SEMI);
			repeat ($urandom_range(0, 6)) add_byte(rand_text_byte());
			push_crlf();
		end else begin
			do c = rand_text_byte();
			while ((c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || (c >= CH_LOW_A && c <= CH_LOW_F) ||
				(c >= CH_UP_A && c <= CH_UP_F));
			add_byte(c);
			repeat ($urandom_range(0, 3)) add_byte(rand_text_byte());
			add_byte(hcd_pkg::CH_LF);
		end
		repeat (size) add_byte(8'($urandom_range(0, 255)));
		// separator, sometimes garbage since it goes unchecked
		if ($urandom_range(0, 4) == 0) begin
			add_byte(8'($urandom_range(0, 255)));
			add_byte(8'($urandom_range(0, 255)));
		end else begin
			push_crlf();
		end
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		sb.take_byte(b);
		sent++;
		calm = (sent >= 300 && sent < 420);
	endtask

	// Drain the block: no input, all results back, pipeline empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_mode(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Cut into the parse with a burst of raw bytes, then resume chunked mode
	task automatic raw_burst();
		settle();
		write_cfg(1'b0);
		repeat ($urandom_range(3, 20)) send_byte(8'($urandom_range(0, 255)));
		settle();
		write_cfg(1'b1);
	endtask

	task automatic flush_stream(input bit allow_raw);
		while (stream_q.size() != 0) begin
			if (allow_raw && $urandom_range(0, 79) == 0) raw_burst();
			send_byte(stream_q.pop_front());
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		tail_kind_t  tail;
		int unsigned pick;
		logic [7:0]  c;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: odd blanks, upper case prefix, extreme bytes
		write_cfg(1'b1);
		add_byte(hcd_pkg::CH_VT);
		add_byte(hcd_pkg::CH_FF);
		add_byte(hcd_pkg::CH_SPACE);
		push_text("0X2");
		push_crlf();
		add_byte(8'h00);
		add_byte(8'hFF);
		push_crlf();
		// lone leading zero, extension, LF as data, unchecked separator
		push_text("01;q");
		add_byte(hcd_pkg::CH_LF);
		add_byte(hcd_pkg::CH_LF);
		push_text("zz");
		flush_stream(1'b0);
		// raw bytes in the middle of a size line, then resume the parse
		push_text("+1");
		flush_stream(1'b0);
		settle();
		write_cfg(1'b0);
		send_byte(8'h00);
		send_byte(8'hFF);
		settle();
		write_cfg(1'b1);
		push_text("G");
		add_byte(hcd_pkg::CH_LF);
		add_byte(8'h80);
		push_crlf();
		flush_stream(1'b0);

		// Random chunks with raw bursts cutting in anywhere
		while (sent < TOTAL_ITEMS) begin
			add_chunk();
			flush_stream(1'b1);
		end

		// Close the body with one of the terminal size lines
		tail = tail_kind_t'($urandom_range(0, 8));
		case (tail)
			TAIL_ZERO: push_text("0");
			TAIL_NEG_EXT: begin
				add_byte(hcd_pkg::CH_TAB);
				push_text("-1a;x");
			end
			TAIL_BLANKS: begin
				add_byte(hcd_pkg::CH_SPACE);
				add_byte(hcd_pkg::CH_FF);
			end
			TAIL_BARE_PREFIX: push_text("0x");
			TAIL_SIGN_BLANK: push_text("+ 5");
			TAIL_EMPTY: ;
			TAIL_NEG_HUGE: push_text("-FFFFFFFFFFF");
			TAIL_ZEROS_EXT: push_text("000;e");
			default: push_text("100000003");
		endcase
		if (tail == TAIL_EMPTY || tail == TAIL_ZEROS_EXT) add_byte(hcd_pkg::CH_LF);
		else push_crlf();

		if (tail == TAIL_HUGE) begin
			// saturated size: none of these bytes may end the chunk
			repeat (40) add_byte(8'($urandom_range(0, 255)));
			flush_stream(1'b0);
		end else begin
			// trailer lines that are not empty, then the empty one
			repeat ($urandom_range(0, 3)) begin
				pick = $urandom_range(0, 2);
				if (pick == 0) begin
					do c = rand_text_byte(); while (c == hcd_pkg::CH_CR);
					add_byte(c);
					add_byte(hcd_pkg::CH_LF);
				end else if (pick == 1) begin
					add_byte(hcd_pkg::CH_CR);
					push_crlf();
				end else begin
					repeat ($urandom_range(2, 10)) add_byte(rand_text_byte());
					push_crlf();
				end
			end
			if ($urandom_range(0, 1)) add_byte(hcd_pkg::CH_LF);
			else push_crlf();
			// bytes after the end are dropped in either mode
			repeat (6) add_byte(8'($urandom_range(0, 255)));
			flush_stream(1'b0);
			settle();
			write_cfg(1'b0);
			repeat (6) add_byte(8'($urandom_range(0, 255)));
			flush_stream(1'b0);
		end

		settle();
		repeat (END_CYCLES) @(posedge clk);
		if (sb.failures == 0) begin
			$display("** http_chunked_deframer_core: PASSED **");
		end else begin
			$display("** http_chunked_deframer_core: FAILED **");
		end
		$finish;
	end

endmodule
